FILE: rtl/cpfp_pkg.sv
// ----------------------------------------------------------------------------
// cpfp_pkg
// Shared types, sizes, codes and pointer helpers of the CAN pair frame packer.
// ----------------------------------------------------------------------------
package cpfp_pkg;

    localparam int STAGE_PAIRS   = 64;
    localparam int QUEUE_TRIPLES = 64;

    localparam int SP_AW = $clog2(STAGE_PAIRS);
    localparam int SP_CW = $clog2(STAGE_PAIRS + 1);
    localparam int TQ_AW = $clog2(QUEUE_TRIPLES);
    localparam int TQ_CW = $clog2(QUEUE_TRIPLES + 1);

    localparam logic [3:0] DLC_NONE   = 4'd0;
    localparam logic [3:0] DLC_SINGLE = 4'd4;
    localparam logic [3:0] DLC_MORE   = 4'd8;
    localparam logic [3:0] DLC_LAST   = 4'd9;

    localparam logic CFG_IDX_OWN_ADDRESS = 1'b0;

    typedef enum logic [1:0] {
        CMD_STAGE  = 2'd0,
        CMD_COMMIT = 2'd1,
        CMD_FRAME  = 2'd2
    } t_command;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CM_RD,
        ST_CM_WR,
        ST_FR_1,
        ST_FR_2,
        ST_FR_3,
        ST_DONE
    } t_state;

    typedef logic [SP_AW-1:0] t_sptr;
    typedef logic [SP_CW-1:0] t_scnt;
    typedef logic [TQ_AW-1:0] t_tptr;
    typedef logic [TQ_CW-1:0] t_tcnt;

    typedef struct packed {
        logic [15:0] index;
        logic [15:0] value;
    } t_pair;

    typedef struct packed {
        logic [4:0]  dest;
        logic [15:0] index;
        logic [15:0] value;
    } t_triple;

    typedef struct packed {
        logic [1:0]  command;
        logic [4:0]  dest;
        logic [15:0] index;
        logic [15:0] value;
    } t_cmd;

    typedef struct packed {
        logic        frame_valid;
        logic [10:0] can_id;
        logic [3:0]  dlc;
        logic [15:0] index_a;
        logic [15:0] value_a;
        logic [15:0] index_b;
        logic [15:0] value_b;
        logic        tx_enable;
    } t_result;

    function automatic t_sptr sptr_inc(input t_sptr p);
        return (p == t_sptr'(STAGE_PAIRS - 1)) ? '0 : t_sptr'(p + 1'b1);
    endfunction

    function automatic t_tptr tptr_inc(input t_tptr p);
        return (p == t_tptr'(QUEUE_TRIPLES - 1)) ? '0 : t_tptr'(p + 1'b1);
    endfunction

endpackage

FILE: rtl/cpfp_ram.sv
// ----------------------------------------------------------------------------
// cpfp_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cpfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/cpfp_ctrl.sv
// ----------------------------------------------------------------------------
// cpfp_ctrl
// Sequencer over the staging RAM and the transmit queue RAM: stages pairs,
// walks staged pairs into the queue on commit, and reads up to three queue
// entries to build a frame.
// ----------------------------------------------------------------------------
module cpfp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  cpfp_pkg::t_cmd    i_cmd,
    input  logic [5:0]        i_own_address,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output cpfp_pkg::t_result o_res
);

    cpfp_pkg::t_state  r_state, n_state;
    cpfp_pkg::t_sptr   r_shead, n_shead, r_stail, n_stail;
    cpfp_pkg::t_scnt   r_scount, n_scount;
    cpfp_pkg::t_tptr   r_thead, n_thead, r_ttail, n_ttail;
    cpfp_pkg::t_tcnt   r_tcount, n_tcount;
    logic              r_irq, n_irq;
    logic [4:0]        r_dest, n_dest;
    cpfp_pkg::t_triple r_first, n_first, r_second, n_second;
    cpfp_pkg::t_result r_res, n_res;

    logic              s_we;
    cpfp_pkg::t_sptr   s_waddr, s_raddr;
    cpfp_pkg::t_pair   s_wdata, s_rdata;
    logic              t_we;
    cpfp_pkg::t_tptr   t_raddr;
    cpfp_pkg::t_triple t_wdata, t_rdata;
    logic              have2, have3;

    cpfp_ram #(
        .WIDTH ($bits(cpfp_pkg::t_pair)),
        .DEPTH (cpfp_pkg::STAGE_PAIRS)
    ) u_stage_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    cpfp_ram #(
        .WIDTH ($bits(cpfp_pkg::t_triple)),
        .DEPTH (cpfp_pkg::QUEUE_TRIPLES)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (r_thead),
        .i_wdata (t_wdata),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cpfp_pkg::ST_IDLE;
            r_shead  <= '0;
            r_stail  <= '0;
            r_scount <= '0;
            r_thead  <= '0;
            r_ttail  <= '0;
            r_tcount <= '0;
            r_irq    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_shead  <= n_shead;
            r_stail  <= n_stail;
            r_scount <= n_scount;
            r_thead  <= n_thead;
            r_ttail  <= n_ttail;
            r_tcount <= n_tcount;
            r_irq    <= n_irq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dest   <= n_dest;
        r_first  <= n_first;
        r_second <= n_second;
        r_res    <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_shead  = r_shead;
        n_stail  = r_stail;
        n_scount = r_scount;
        n_thead  = r_thead;
        n_ttail  = r_ttail;
        n_tcount = r_tcount;
        n_irq    = r_irq;
        n_dest   = r_dest;
        n_first  = r_first;
        n_second = r_second;
        n_res    = r_res;
        s_we     = 1'b0;
        s_waddr  = r_shead;
        s_wdata  = '{index: i_cmd.index, value: i_cmd.value};
        s_raddr  = r_stail;
        t_we     = 1'b0;
        t_wdata  = '{dest: r_dest, index: s_rdata.index, value: s_rdata.value};
        t_raddr  = r_ttail;
        have2    = (r_tcount > cpfp_pkg::t_tcnt'(1)) && (r_second.dest == r_first.dest);
        have3    = have2 && (r_tcount > cpfp_pkg::t_tcnt'(2))
                   && (t_rdata.dest == r_first.dest);
        o_cmd_ready = (r_state == cpfp_pkg::ST_IDLE);
        o_res_valid = (r_state == cpfp_pkg::ST_DONE);

        unique case (r_state)
            cpfp_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_res   = '0;
                    n_state = cpfp_pkg::ST_DONE;
                    case (i_cmd.command)
                        cpfp_pkg::CMD_STAGE: begin
                            if (r_scount != cpfp_pkg::t_scnt'(cpfp_pkg::STAGE_PAIRS)) begin
                                s_we     = 1'b1;
                                n_shead  = cpfp_pkg::sptr_inc(r_shead);
                                n_scount = cpfp_pkg::t_scnt'(r_scount + 1'b1);
                            end
                        end
                        cpfp_pkg::CMD_COMMIT: begin
                            n_dest  = i_cmd.dest;
                            n_irq   = 1'b1;
                            n_state = cpfp_pkg::ST_CM_RD;
                        end
                        cpfp_pkg::CMD_FRAME: begin
                            if (r_tcount == '0) begin
                                n_irq = 1'b0;
                            end else begin
                                n_state = cpfp_pkg::ST_FR_1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            cpfp_pkg::ST_CM_RD: begin
                if (r_scount == '0) begin
                    n_state = cpfp_pkg::ST_DONE;
                end else begin
                    n_stail  = cpfp_pkg::sptr_inc(r_stail);
                    n_scount = cpfp_pkg::t_scnt'(r_scount - 1'b1);
                    n_state  = cpfp_pkg::ST_CM_WR;
                end
            end
            cpfp_pkg::ST_CM_WR: begin
                if (r_tcount != cpfp_pkg::t_tcnt'(cpfp_pkg::QUEUE_TRIPLES)) begin
                    t_we     = 1'b1;
                    n_thead  = cpfp_pkg::tptr_inc(r_thead);
                    n_tcount = cpfp_pkg::t_tcnt'(r_tcount + 1'b1);
                end
                n_state = cpfp_pkg::ST_CM_RD;
            end
            cpfp_pkg::ST_FR_1: begin
                n_first = t_rdata;
                t_raddr = cpfp_pkg::tptr_inc(r_ttail);
                n_state = cpfp_pkg::ST_FR_2;
            end
            cpfp_pkg::ST_FR_2: begin
                n_second = t_rdata;
                t_raddr  = cpfp_pkg::tptr_inc(cpfp_pkg::tptr_inc(r_ttail));
                n_state  = cpfp_pkg::ST_FR_3;
            end
            cpfp_pkg::ST_FR_3: begin
                n_res.frame_valid = 1'b1;
                n_res.can_id      = {r_first.dest, i_own_address};
                n_res.index_a     = r_first.index;
                n_res.value_a     = r_first.value;
                if (have2) begin
                    n_res.index_b = r_second.index;
                    n_res.value_b = r_second.value;
                    n_res.dlc     = have3 ? cpfp_pkg::DLC_MORE : cpfp_pkg::DLC_LAST;
                    n_ttail       = cpfp_pkg::tptr_inc(cpfp_pkg::tptr_inc(r_ttail));
                    n_tcount      = cpfp_pkg::t_tcnt'(r_tcount - 2'd2);
                end else begin
                    n_res.dlc     = cpfp_pkg::DLC_SINGLE;
                    n_ttail       = cpfp_pkg::tptr_inc(r_ttail);
                    n_tcount      = cpfp_pkg::t_tcnt'(r_tcount - 1'b1);
                end
                n_state = cpfp_pkg::ST_DONE;
            end
            cpfp_pkg::ST_DONE: begin
                if (i_res_ready) begin
                    n_state = cpfp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cpfp_pkg::ST_IDLE;
            end
        endcase

        o_res           = r_res;
        o_res.tx_enable = r_irq;
    end

endmodule

FILE: rtl/can_pair_frame_packer.sv
// ----------------------------------------------------------------------------
// can_pair_frame_packer
// Transmit side of a CAN index/value transfer scheme. Each command beat on the
// input channel (i_valid/o_ready) yields exactly one result beat on the
// output channel (o_valid/i_ready). Stage queues one pair in the staging RAM,
// commit moves every staged pair into the transmit queue RAM tagged with a
// destination, frame request pops one or two same-destination entries and
// returns a frame with identifier dest*64 + own_address.
// A frame request reads three queue RAM entries through the single read port;
// a commit does one staging RAM read and, unless the queue is full, one queue
// RAM write per pair, so a pair meeting a full queue is dropped. The sequencer
// takes the next beat in the cycle after its result moves to the output
// register. A stalled receiver holds the result; the next result then waits
// in the sequencer, which takes no further beat until the output register
// frees. Synchronous reset empties both queues and clears the interrupt-enable
// flag and own_address; RAM contents are not cleared.
// own_address is written over the APB port at byte address 0.
// ----------------------------------------------------------------------------
module can_pair_frame_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [4:0]  i_dest,
    input  logic [15:0] i_index,
    input  logic [15:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_frame_valid,
    output logic [10:0] o_can_id,
    output logic [3:0]  o_dlc,
    output logic [15:0] o_index_a,
    output logic [15:0] o_value_a,
    output logic [15:0] o_index_b,
    output logic [15:0] o_value_b,
    output logic        o_tx_enable
);

    logic [5:0]        r_own_address;
    logic              r_out_valid;
    cpfp_pkg::t_result r_out;
    cpfp_pkg::t_cmd    cmd;
    cpfp_pkg::t_result res;
    logic              res_valid;
    logic              res_ready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == cpfp_pkg::CFG_IDX_OWN_ADDRESS) ?
                    {26'd0, r_own_address} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == cpfp_pkg::CFG_IDX_OWN_ADDRESS) begin
            r_own_address <= pwdata[5:0];
        end
    end

    assign cmd = '{command: i_command, dest: i_dest, index: i_index, value: i_value};

    cpfp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (i_valid),
        .o_cmd_ready   (o_ready),
        .i_cmd         (cmd),
        .i_own_address (r_own_address),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_frame_valid = r_out.frame_valid;
    assign o_can_id      = r_out.can_id;
    assign o_dlc         = r_out.dlc;
    assign o_index_a     = r_out.index_a;
    assign o_value_a     = r_out.value_a;
    assign o_index_b     = r_out.index_b;
    assign o_value_b     = r_out.value_b;
    assign o_tx_enable   = r_out.tx_enable;

endmodule
